@@ rtl/ubsc_pkg.sv @@
// Shared types and codes for the unbiased box shrink and classify unit.
package ubsc_pkg;

   // Input function codes as they arrive on req_func
   localparam logic [1:0] FUNC_START    = 2'd0;
   localparam logic [1:0] FUNC_SHRINK   = 2'd1;
   localparam logic [1:0] FUNC_CLASSIFY = 2'd2;

   // Decoded operations handed from the front to the back
   localparam logic [1:0] OP_NONE     = 2'd0;
   localparam logic [1:0] OP_START    = 2'd1;
   localparam logic [1:0] OP_SHRINK   = 2'd2;
   localparam logic [1:0] OP_CLASSIFY = 2'd3;

   // Register indexes (byte address is 4 times the index)
   localparam logic [1:0] REG_EXTENT_X   = 2'd0;
   localparam logic [1:0] REG_EXTENT_Y   = 2'd1;
   localparam logic [1:0] REG_EXTENT_Z   = 2'd2;
   localparam logic [1:0] REG_PLANE_MODE = 2'd3;

   localparam int FACE_COUNT    = 6;
   localparam int FACE_IDX_BITS = 3;
   localparam int AXIS_COUNT    = 3;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] coord_x;
      logic [31:0] coord_y;
      logic [31:0] coord_z;
   } cmd_type;

   typedef struct packed {
      logic                     biased;
      logic                     face_moved;
      logic [FACE_IDX_BITS-1:0] moved_face;
   } rsp_type;

   typedef struct packed {
      logic [31:0] extent_x;
      logic [31:0] extent_y;
      logic [31:0] extent_z;
      logic        plane_mode;
   } cfg_type;

endpackage

@@ rtl/ubsc_queue.sv @@
// Two-entry word queue with push/full and pop/empty sides.
module ubsc_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int DEPTH     = 2;
   localparam int PTR_BITS  = $clog2(DEPTH);
   localparam int CNT_BITS  = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/ubsc_front.sv @@
// Front end: decode each incoming word into an operation and queue it.
module ubsc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [1:0]           req_func,
   input  logic [31:0]          req_coord_x,
   input  logic [31:0]          req_coord_y,
   input  logic [31:0]          req_coord_z,
   input  logic                 req_surface_grain,
   input  logic                 cmd_pop,
   output ubsc_pkg::cmd_type    cmd_data,
   output logic                 cmd_empty
);

   ubsc_pkg::cmd_type cmd_dec;

   // A shrink without the surface flag behaves like the unused code: no effect.
   always_comb begin
      cmd_dec.coord_x = req_coord_x;
      cmd_dec.coord_y = req_coord_y;
      cmd_dec.coord_z = req_coord_z;
      case (req_func)
         ubsc_pkg::FUNC_START: begin
            cmd_dec.op = ubsc_pkg::OP_START;
         end
         ubsc_pkg::FUNC_SHRINK: begin
            cmd_dec.op = req_surface_grain ? ubsc_pkg::OP_SHRINK : ubsc_pkg::OP_NONE;
         end
         ubsc_pkg::FUNC_CLASSIFY: begin
            cmd_dec.op = ubsc_pkg::OP_CLASSIFY;
         end
         default: begin
            cmd_dec.op = ubsc_pkg::OP_NONE;
         end
      endcase
   end

   ubsc_queue #(
      .WIDTH($bits(ubsc_pkg::cmd_type))
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (cmd_dec),
      .full      (req_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_data),
      .empty     (cmd_empty)
   );

endmodule

@@ rtl/ubsc_back.sv @@
// Back end: hold the box faces, execute one operation per cycle while the result queue has room, queue results.
module ubsc_back #(
   parameter int COORD_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ubsc_pkg::cfg_type    cfg,
   input  ubsc_pkg::cmd_type    cmd_data,
   input  logic                 cmd_empty,
   output logic                 cmd_pop,
   output ubsc_pkg::rsp_type    rsp_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop
);

   localparam int W = COORD_BITS;
   localparam int FIDX = ubsc_pkg::FACE_IDX_BITS;

   logic [W-1:0]  face_ff [ubsc_pkg::FACE_COUNT];
   logic [W-1:0]  face_in [ubsc_pkg::FACE_COUNT];
   logic [W-1:0]  axis_c  [ubsc_pkg::AXIS_COUNT];
   logic [W-1:0]  gap     [ubsc_pkg::FACE_COUNT];
   logic [ubsc_pkg::FACE_COUNT-1:0] active, ok;
   logic          in_box;
   logic          rsp_full;
   logic          exec;
   logic [FIDX-1:0] pair_idx  [ubsc_pkg::AXIS_COUNT];
   logic [W-1:0]    pair_dist [ubsc_pkg::AXIS_COUNT];
   logic [FIDX-1:0] xy_idx, best_idx;
   logic [W-1:0]    xy_dist;
   ubsc_pkg::rsp_type rsp_in;

   assign exec    = !cmd_empty && !rsp_full;
   assign cmd_pop = exec;

   assign axis_c[0] = W'(cmd_data.coord_x);
   assign axis_c[1] = W'(cmd_data.coord_y);
   assign axis_c[2] = W'(cmd_data.coord_z);

   // Per-face test and distance; even faces are min faces, odd are max faces.
   always_comb begin
      for (int f = 0; f < ubsc_pkg::FACE_COUNT; f++) begin
         active[f] = (f < 4) || !cfg.plane_mode;
         if ((f % 2) == 0) begin
            ok[f]  = axis_c[f >> 1] > face_ff[f];
            gap[f] = axis_c[f >> 1] - face_ff[f];
         end else begin
            ok[f]  = axis_c[f >> 1] < face_ff[f];
            gap[f] = face_ff[f] - axis_c[f >> 1];
         end
      end
      in_box = &(ok | ~active);
   end

   // Nearest face; the lower index keeps the lead on a tie.
   always_comb begin
      for (int a = 0; a < ubsc_pkg::AXIS_COUNT; a++) begin
         if (gap[2*a+1] < gap[2*a]) begin
            pair_idx[a]  = FIDX'(2*a+1);
            pair_dist[a] = gap[2*a+1];
         end else begin
            pair_idx[a]  = FIDX'(2*a);
            pair_dist[a] = gap[2*a];
         end
      end
      if (pair_dist[1] < pair_dist[0]) begin
         xy_idx  = pair_idx[1];
         xy_dist = pair_dist[1];
      end else begin
         xy_idx  = pair_idx[0];
         xy_dist = pair_dist[0];
      end
      best_idx = (!cfg.plane_mode && (pair_dist[2] < xy_dist)) ? pair_idx[2] : xy_idx;
   end

   always_comb begin
      for (int f = 0; f < ubsc_pkg::FACE_COUNT; f++) begin
         face_in[f] = face_ff[f];
      end
      rsp_in = '0;
      case (cmd_data.op)
         ubsc_pkg::OP_START: begin
            face_in[0] = '0;
            face_in[1] = W'(cfg.extent_x);
            face_in[2] = '0;
            face_in[3] = W'(cfg.extent_y);
            face_in[4] = '0;
            face_in[5] = W'(cfg.extent_z);
         end
         ubsc_pkg::OP_SHRINK: begin
            if (in_box) begin
               for (int f = 0; f < ubsc_pkg::FACE_COUNT; f++) begin
                  if (best_idx == FIDX'(f)) begin
                     face_in[f] = axis_c[f >> 1];
                  end
               end
               rsp_in.face_moved = 1'b1;
               rsp_in.moved_face = best_idx;
            end
         end
         ubsc_pkg::OP_CLASSIFY: begin
            rsp_in.biased = !in_box;
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int f = 0; f < ubsc_pkg::FACE_COUNT; f++) begin
            face_ff[f] <= '0;
         end
      end else if (exec) begin
         for (int f = 0; f < ubsc_pkg::FACE_COUNT; f++) begin
            face_ff[f] <= face_in[f];
         end
      end
   end

   ubsc_queue #(
      .WIDTH($bits(ubsc_pkg::rsp_type))
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (exec),
      .push_data (rsp_in),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

endmodule

@@ rtl/unbiased_box_shrink_classify_unit.sv @@
// Top level of the unbiased box shrink and classify unit.
//
// The unit keeps an axis-aligned box of six face positions (xmin, xmax, ymin,
// ymax, zmin, zmax) in unsigned Q16.16 and takes one word per clock while
// req_full is low. A start word loads the box to 0..extent on each axis from
// the csr extent registers. A shrink word with surface_grain set moves the
// face nearest the centroid onto it, but only when the centroid is strictly
// inside every active face; ties go to the lowest face index. A classify word
// reports biased when the centroid sits on or outside any active face. With
// plane_mode set the z faces are still loaded but take no part in shrinking or
// classifying. Every word gives exactly one result word. Throughput is one
// word per clock while the result queue has room, as the face compare and
// nearest-face select in the back end are combinational. The back end
// executes a word straight out of the two-entry command queue and writes its
// result into the two-entry result queue. Both sides stall on their own:
// req_full rises only when the command queue holds two words, rsp_empty falls
// as soon as a result is queued. Change the csr registers only while no words
// are in flight.
module unbiased_box_shrink_classify_unit #(
   parameter int COORD_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // input word channel
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_coord_x,
   input  logic [31:0] req_coord_y,
   input  logic [31:0] req_coord_z,
   input  logic        req_surface_grain,
   // result word channel
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_biased,
   output logic        rsp_face_moved,
   output logic [2:0]  rsp_moved_face,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   ubsc_pkg::cmd_type cmd_data;
   ubsc_pkg::rsp_type rsp_data;
   ubsc_pkg::cfg_type cfg;
   logic              cmd_pop, cmd_empty;

   // Register file: extents and plane mode
   logic [31:0] extent_x_ff, extent_x_in;
   logic [31:0] extent_y_ff, extent_y_in;
   logic [31:0] extent_z_ff, extent_z_in;
   logic        plane_mode_ff, plane_mode_in;
   logic        csr_wr;
   logic [1:0]  csr_idx;

   // No wait states on the register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[3:2];

   always_comb begin
      extent_x_in   = extent_x_ff;
      extent_y_in   = extent_y_ff;
      extent_z_in   = extent_z_ff;
      plane_mode_in = plane_mode_ff;
      if (csr_wr) begin
         case (csr_idx)
            ubsc_pkg::REG_EXTENT_X:   extent_x_in   = csr_pwdata;
            ubsc_pkg::REG_EXTENT_Y:   extent_y_in   = csr_pwdata;
            ubsc_pkg::REG_EXTENT_Z:   extent_z_in   = csr_pwdata;
            ubsc_pkg::REG_PLANE_MODE: plane_mode_in = csr_pwdata[0];
            default:                  plane_mode_in = plane_mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         extent_x_ff   <= '0;
         extent_y_ff   <= '0;
         extent_z_ff   <= '0;
         plane_mode_ff <= 1'b0;
      end else begin
         extent_x_ff   <= extent_x_in;
         extent_y_ff   <= extent_y_in;
         extent_z_ff   <= extent_z_in;
         plane_mode_ff <= plane_mode_in;
      end
   end

   // Read back the addressed register
   always_comb begin
      case (csr_idx)
         ubsc_pkg::REG_EXTENT_X:   csr_prdata = extent_x_ff;
         ubsc_pkg::REG_EXTENT_Y:   csr_prdata = extent_y_ff;
         ubsc_pkg::REG_EXTENT_Z:   csr_prdata = extent_z_ff;
         ubsc_pkg::REG_PLANE_MODE: csr_prdata = {31'd0, plane_mode_ff};
         default:                  csr_prdata = '0;
      endcase
   end

   assign cfg.extent_x   = extent_x_ff;
   assign cfg.extent_y   = extent_y_ff;
   assign cfg.extent_z   = extent_z_ff;
   assign cfg.plane_mode = plane_mode_ff;

   // Front: decode and queue incoming words
   ubsc_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_func          (req_func),
      .req_coord_x       (req_coord_x),
      .req_coord_y       (req_coord_y),
      .req_coord_z       (req_coord_z),
      .req_surface_grain (req_surface_grain),
      .cmd_pop           (cmd_pop),
      .cmd_data          (cmd_data),
      .cmd_empty         (cmd_empty)
   );

   // Back: update the box and produce result words
   ubsc_back #(
      .COORD_BITS(COORD_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_data  (cmd_data),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

   assign rsp_biased     = rsp_data.biased;
   assign rsp_face_moved = rsp_data.face_moved;
   assign rsp_moved_face = rsp_data.moved_face;

endmodule
